/* hdl/quaternion_point_rotation_unit_macros.svh */
// Assertion macros used by the checker of the rotation unit.
`ifndef QUATERNION_POINT_ROTATION_UNIT_MACROS_SVH
`define QUATERNION_POINT_ROTATION_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define QPR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rotation unit check failed");

// Next-cycle implication, disabled while reset is high.
`define QPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rotation unit check failed");

`endif

/* hdl/qpr_pkg.sv */
// Shared constants and types of the quaternion point rotation unit.
`timescale 1ns / 1ps

package qpr_pkg;

   localparam int MAT_BITS    = 18;
   localparam int MAT_FRAC    = 16;
   localparam int MAT_MAX     = 131071;
   localparam int MAT_MIN     = -131072;
   localparam int MAT_ENTRIES = 9;

   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_QUAT_W     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_QUAT_X     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_QUAT_Y     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_QUAT_Z     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CENTER_X   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CENTER_Y   = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CENTER_Z   = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_QUAT_VALID = 3'd7;

   localparam int STATUS_BITS = 2;
   typedef logic [STATUS_BITS-1:0] status_type;
   localparam status_type ST_ROTATED   = 2'd0;
   localparam status_type ST_HELD      = 2'd1;
   localparam status_type ST_NOT_READY = 2'd2;
   localparam status_type ST_SATURATED = 2'd3;

   typedef logic signed [MAT_BITS-1:0] mat_entry_type;

endpackage

/* hdl/qpr_fifo.sv */
// Small register-based first-in first-out queue.
`timescale 1ns / 1ps

module qpr_fifo #(
   parameter int  WIDTH    = 8,
   parameter int  DEPTH    = 4,
   localparam int PTR_BITS = $clog2(DEPTH),
   localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CNT_BITS'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_BITS'(1);
         2'b01:   count_in = count_ff - CNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* hdl/qpr_matrix.sv */
// Two-stage rotation matrix builder fed by the quaternion registers.
`timescale 1ns / 1ps

module qpr_matrix import qpr_pkg::*; #(
   parameter int  QUAT_BITS = 16,
   localparam int PROD_BITS = 2 * QUAT_BITS,
   localparam int EXACT_BITS = 2 * QUAT_BITS + 3,
   localparam int RND_BITS  = EXACT_BITS + 1,
   localparam int SHIFT     = 2 * (QUAT_BITS - 2) - MAT_FRAC
) (
   input  logic                        clock,
   input  logic signed [QUAT_BITS-1:0] quat_w,
   input  logic signed [QUAT_BITS-1:0] quat_x,
   input  logic signed [QUAT_BITS-1:0] quat_y,
   input  logic signed [QUAT_BITS-1:0] quat_z,
   output mat_entry_type               mat [MAT_ENTRIES]
);

   localparam logic signed [EXACT_BITS-1:0] ONE  = EXACT_BITS'(1) << (2 * (QUAT_BITS - 2));
   localparam logic signed [RND_BITS-1:0]   HALF = RND_BITS'(1) << (SHIFT - 1);
   localparam logic signed [RND_BITS-1:0]   LIM_MAX = RND_BITS'(MAT_MAX);
   localparam logic signed [RND_BITS-1:0]   LIM_MIN = RND_BITS'(MAT_MIN);

   logic signed [PROD_BITS-1:0] xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, xw_ff, yw_ff, zw_ff;
   logic signed [EXACT_BITS-1:0] exact [MAT_ENTRIES];
   mat_entry_type                mat_ff [MAT_ENTRIES];
   mat_entry_type                mat_in [MAT_ENTRIES];

   // Round half up by SHIFT bits, then clamp to the matrix entry range.
   function automatic mat_entry_type round_sat(input logic signed [EXACT_BITS-1:0] v);
      logic signed [RND_BITS-1:0] t;
      logic signed [RND_BITS-1:0] q;
      t = RND_BITS'(v) + HALF;
      q = t >>> SHIFT;
      if (q > LIM_MAX) begin
         return MAT_BITS'(MAT_MAX);
      end else if (q < LIM_MIN) begin
         return MAT_BITS'(MAT_MIN);
      end
      return q[MAT_BITS-1:0];
   endfunction

   always_ff @(posedge clock) begin
      xx_ff <= quat_x * quat_x;
      yy_ff <= quat_y * quat_y;
      zz_ff <= quat_z * quat_z;
      xy_ff <= quat_x * quat_y;
      xz_ff <= quat_x * quat_z;
      yz_ff <= quat_y * quat_z;
      xw_ff <= quat_x * quat_w;
      yw_ff <= quat_y * quat_w;
      zw_ff <= quat_z * quat_w;
   end

   always_comb begin
      exact[0] = ONE - ((EXACT_BITS'(yy_ff) + EXACT_BITS'(zz_ff)) <<< 1);
      exact[1] = (EXACT_BITS'(xy_ff) - EXACT_BITS'(zw_ff)) <<< 1;
      exact[2] = (EXACT_BITS'(xz_ff) + EXACT_BITS'(yw_ff)) <<< 1;
      exact[3] = (EXACT_BITS'(xy_ff) + EXACT_BITS'(zw_ff)) <<< 1;
      exact[4] = ONE - ((EXACT_BITS'(xx_ff) + EXACT_BITS'(zz_ff)) <<< 1);
      exact[5] = (EXACT_BITS'(yz_ff) - EXACT_BITS'(xw_ff)) <<< 1;
      exact[6] = (EXACT_BITS'(xz_ff) - EXACT_BITS'(yw_ff)) <<< 1;
      exact[7] = (EXACT_BITS'(yz_ff) + EXACT_BITS'(xw_ff)) <<< 1;
      exact[8] = ONE - ((EXACT_BITS'(xx_ff) + EXACT_BITS'(yy_ff)) <<< 1);
      for (int i = 0; i < MAT_ENTRIES; i++) begin
         mat_in[i] = round_sat(exact[i]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAT_ENTRIES; i++) begin
         mat_ff[i] <= mat_in[i];
      end
   end

   assign mat = mat_ff;

endmodule

/* hdl/qpr_front.sv */
// Front end: input register, classification and center offset.
`timescale 1ns / 1ps

module qpr_front import qpr_pkg::*; #(
   parameter int  COORD_BITS = 24,
   localparam int D_BITS     = COORD_BITS + 1,
   localparam int ENTRY_BITS = 3 * COORD_BITS + 3 * D_BITS + STATUS_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic signed [COORD_BITS-1:0] req_coord_x,
   input  logic signed [COORD_BITS-1:0] req_coord_y,
   input  logic signed [COORD_BITS-1:0] req_coord_z,
   input  logic                         req_hold,
   output logic                         full,
   input  logic                         quat_valid,
   input  logic signed [COORD_BITS-1:0] center [3],
   output logic                         q_push,
   input  logic                         q_full,
   output logic [ENTRY_BITS-1:0]        q_data
);

   logic                         valid_ff, valid_in;
   logic signed [COORD_BITS-1:0] x_ff, y_ff, z_ff;
   logic                         hold_ff;
   logic                         accept;
   status_type                   cls;
   logic signed [D_BITS-1:0]     dx, dy, dz;

   assign full     = valid_ff && q_full;
   assign accept   = push && !full;
   assign q_push   = valid_ff && !q_full;
   assign valid_in = accept || (valid_ff && q_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff    <= req_coord_x;
         y_ff    <= req_coord_y;
         z_ff    <= req_coord_z;
         hold_ff <= req_hold;
      end
   end

   // A missing quaternion wins over the hold flag.
   always_comb begin
      priority if (!quat_valid) begin
         cls = ST_NOT_READY;
      end else if (hold_ff) begin
         cls = ST_HELD;
      end else begin
         cls = ST_ROTATED;
      end
   end

   assign dx = D_BITS'(x_ff) - D_BITS'(center[0]);
   assign dy = D_BITS'(y_ff) - D_BITS'(center[1]);
   assign dz = D_BITS'(z_ff) - D_BITS'(center[2]);

   assign q_data = {x_ff, y_ff, z_ff, dx, dy, dz, cls};

endmodule

/* hdl/qpr_back.sv */
// Back end: multiply by the matrix, round, add the center back, saturate.
`timescale 1ns / 1ps

module qpr_back import qpr_pkg::*; #(
   parameter int  COORD_BITS = 24,
   localparam int D_BITS     = COORD_BITS + 1,
   localparam int ENTRY_BITS = 3 * COORD_BITS + 3 * D_BITS + STATUS_BITS,
   localparam int RES_BITS   = 3 * COORD_BITS + STATUS_BITS,
   localparam int PR_BITS    = MAT_BITS + D_BITS,
   localparam int ACC_BITS   = PR_BITS + 2,
   localparam int RS_BITS    = ACC_BITS - MAT_FRAC,
   localparam int SUM_BITS   = RS_BITS + 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   input  logic [ENTRY_BITS-1:0]        q_data,
   output logic                         q_pop,
   input  mat_entry_type                mat [MAT_ENTRIES],
   input  logic signed [COORD_BITS-1:0] center [3],
   input  logic                         out_full,
   output logic                         out_push,
   output logic [RES_BITS-1:0]          out_data
);

   localparam int DZ_LSB = STATUS_BITS;
   localparam int DY_LSB = DZ_LSB + D_BITS;
   localparam int DX_LSB = DY_LSB + D_BITS;
   localparam int PZ_LSB = DX_LSB + D_BITS;
   localparam int PY_LSB = PZ_LSB + COORD_BITS;
   localparam int PX_LSB = PY_LSB + COORD_BITS;

   localparam logic signed [ACC_BITS-1:0] HALF = ACC_BITS'(1) << (MAT_FRAC - 1);
   localparam logic signed [SUM_BITS-1:0] CMAX = SUM_BITS'({1'b0, {(COORD_BITS-1){1'b1}}});
   localparam logic signed [SUM_BITS-1:0] CMIN = -CMAX - SUM_BITS'(1);

   logic signed [COORD_BITS-1:0] q_p [3];
   logic signed [D_BITS-1:0]     q_d [3];
   status_type                   q_cls;

   logic                         adv;
   logic                         v1_ff, v2_ff, v3_ff;
   logic signed [PR_BITS-1:0]    prod_ff [MAT_ENTRIES];
   logic signed [PR_BITS-1:0]    prod_in [MAT_ENTRIES];
   logic signed [COORD_BITS-1:0] p1_ff [3];
   logic signed [COORD_BITS-1:0] p2_ff [3];
   status_type                   cls1_ff, cls2_ff;
   logic signed [ACC_BITS-1:0]   acc [3];
   logic signed [RS_BITS-1:0]    rs_ff [3];
   logic signed [SUM_BITS-1:0]   sum [3];
   logic signed [COORD_BITS-1:0] res_in [3];
   logic signed [COORD_BITS-1:0] res_ff [3];
   logic [2:0]                   sat;
   status_type                   status_in, status_ff;

   assign q_p[0] = q_data[PX_LSB +: COORD_BITS];
   assign q_p[1] = q_data[PY_LSB +: COORD_BITS];
   assign q_p[2] = q_data[PZ_LSB +: COORD_BITS];
   assign q_d[0] = q_data[DX_LSB +: D_BITS];
   assign q_d[1] = q_data[DY_LSB +: D_BITS];
   assign q_d[2] = q_data[DZ_LSB +: D_BITS];
   assign q_cls  = q_data[STATUS_BITS-1:0];

   // Hold the whole pipe only when the last stage cannot drain.
   assign adv      = !(v3_ff && out_full);
   assign q_pop    = adv && !q_empty;
   assign out_push = v3_ff && !out_full;

   always_comb begin
      for (int k = 0; k < MAT_ENTRIES; k++) begin
         prod_in[k] = mat[k] * q_d[k % 3];
      end
   end

   // Round half up to the coordinate fraction: keep the upper bits.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc[i] = ACC_BITS'(prod_ff[3*i]) + ACC_BITS'(prod_ff[3*i+1])
                + ACC_BITS'(prod_ff[3*i+2]) + HALF;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum[i] = SUM_BITS'(rs_ff[i]) + SUM_BITS'(center[i]);
         sat[i] = 1'b0;
         if (cls2_ff != ST_ROTATED) begin
            res_in[i] = p2_ff[i];
         end else if (sum[i] > CMAX) begin
            res_in[i] = CMAX[COORD_BITS-1:0];
            sat[i]    = 1'b1;
         end else if (sum[i] < CMIN) begin
            res_in[i] = CMIN[COORD_BITS-1:0];
            sat[i]    = 1'b1;
         end else begin
            res_in[i] = sum[i][COORD_BITS-1:0];
         end
      end
      status_in = (|sat) ? ST_SATURATED : cls2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= !q_empty;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < MAT_ENTRIES; k++) begin
            prod_ff[k] <= prod_in[k];
         end
         for (int i = 0; i < 3; i++) begin
            p1_ff[i]  <= q_p[i];
            p2_ff[i]  <= p1_ff[i];
            rs_ff[i]  <= acc[i][ACC_BITS-1:MAT_FRAC];
            res_ff[i] <= res_in[i];
         end
         cls1_ff   <= q_cls;
         cls2_ff   <= cls1_ff;
         status_ff <= status_in;
      end
   end

   assign out_data = {res_ff[0], res_ff[1], res_ff[2], status_ff};

endmodule

/* hdl/quaternion_point_rotation_unit.sv */
// Top level of the quaternion point rotation unit.
`timescale 1ns / 1ps
//
// Rotates 3D points about a programmable center by a programmable quaternion.
// Input side is a queue: drive push with a point and its hold flag; the
// transaction is taken at a clock edge with push high and full low.
// Result side is a queue too: while empty is low the oldest result sits on
// the rsp_ ports; it is consumed at an edge with pop high and empty low.
// Configuration: csr_we writes csr_wdata into register csr_index at once.
// Write it only while no transaction is in flight; the matrix follows the
// quaternion registers via its product and matrix registers, before any new
// point reaches it. Points go front, middle queue, back end, result queue.
// Throughput: one point per cycle unless the receiver stalls, set by the
// front register and the three-stage multiply / round / saturate pipeline
// in the back end. A four-entry queue parts front from back; a two-entry
// result queue parts the back end from the receiver. When the receiver
// stalls, the back end holds, the middle queue fills, and then full rises.
// Reset empties every queue, loads the identity quaternion, a zero center
// and clears the quaternion-valid flag (points pass through as not ready).
//
module quaternion_point_rotation_unit import qpr_pkg::*; #(
   parameter int  COORD_BITS = 24,
   parameter int  QUAT_BITS  = 16,
   localparam int CSR_BITS   = (COORD_BITS > QUAT_BITS) ? COORD_BITS : QUAT_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   // input transactions
   input  logic                         push,
   output logic                         full,
   input  logic signed [COORD_BITS-1:0] req_coord_x,
   input  logic signed [COORD_BITS-1:0] req_coord_y,
   input  logic signed [COORD_BITS-1:0] req_coord_z,
   input  logic                         req_hold,
   // result transactions
   output logic                         empty,
   input  logic                         pop,
   output logic signed [COORD_BITS-1:0] rsp_out_x,
   output logic signed [COORD_BITS-1:0] rsp_out_y,
   output logic signed [COORD_BITS-1:0] rsp_out_z,
   output logic [STATUS_BITS-1:0]       rsp_status,
   // configuration writes
   input  logic                         csr_we,
   input  logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [CSR_BITS-1:0]          csr_wdata
);

   localparam int D_BITS     = COORD_BITS + 1;
   localparam int ENTRY_BITS = 3 * COORD_BITS + 3 * D_BITS + STATUS_BITS;
   localparam int RES_BITS   = 3 * COORD_BITS + STATUS_BITS;
   localparam int MID_DEPTH  = 4;
   localparam int OUT_DEPTH  = 2;

   // Configuration registers.
   logic signed [QUAT_BITS-1:0]  quat_w_ff, quat_w_in;
   logic signed [QUAT_BITS-1:0]  quat_x_ff, quat_x_in;
   logic signed [QUAT_BITS-1:0]  quat_y_ff, quat_y_in;
   logic signed [QUAT_BITS-1:0]  quat_z_ff, quat_z_in;
   logic signed [COORD_BITS-1:0] center_ff [3];
   logic signed [COORD_BITS-1:0] center_in [3];
   logic                         quat_valid_ff, quat_valid_in;

   mat_entry_type                mat [MAT_ENTRIES];

   logic                         mid_push, mid_full, mid_pop, mid_empty;
   logic [ENTRY_BITS-1:0]        mid_wr_data, mid_rd_data;
   logic                         res_push, res_full;
   logic [RES_BITS-1:0]          res_wr_data, res_rd_data;

   // Decode configuration writes; every index names a register.
   always_comb begin
      quat_w_in     = quat_w_ff;
      quat_x_in     = quat_x_ff;
      quat_y_in     = quat_y_ff;
      quat_z_in     = quat_z_ff;
      center_in     = center_ff;
      quat_valid_in = quat_valid_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_QUAT_W:     quat_w_in     = csr_wdata[QUAT_BITS-1:0];
            REG_QUAT_X:     quat_x_in     = csr_wdata[QUAT_BITS-1:0];
            REG_QUAT_Y:     quat_y_in     = csr_wdata[QUAT_BITS-1:0];
            REG_QUAT_Z:     quat_z_in     = csr_wdata[QUAT_BITS-1:0];
            REG_CENTER_X:   center_in[0]  = csr_wdata[COORD_BITS-1:0];
            REG_CENTER_Y:   center_in[1]  = csr_wdata[COORD_BITS-1:0];
            REG_CENTER_Z:   center_in[2]  = csr_wdata[COORD_BITS-1:0];
            REG_QUAT_VALID: quat_valid_in = csr_wdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_w_ff     <= QUAT_BITS'(1) << (QUAT_BITS - 2);
         quat_x_ff     <= '0;
         quat_y_ff     <= '0;
         quat_z_ff     <= '0;
         center_ff     <= '{default: '0};
         quat_valid_ff <= 1'b0;
      end else begin
         quat_w_ff     <= quat_w_in;
         quat_x_ff     <= quat_x_in;
         quat_y_ff     <= quat_y_in;
         quat_z_ff     <= quat_z_in;
         center_ff     <= center_in;
         quat_valid_ff <= quat_valid_in;
      end
   end

   // Matrix tracks the quaternion registers continuously.
   qpr_matrix #(
      .QUAT_BITS (QUAT_BITS)
   ) u_matrix (
      .clock  (clock),
      .quat_w (quat_w_ff),
      .quat_x (quat_x_ff),
      .quat_y (quat_y_ff),
      .quat_z (quat_z_ff),
      .mat    (mat)
   );

   qpr_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .req_coord_x (req_coord_x),
      .req_coord_y (req_coord_y),
      .req_coord_z (req_coord_z),
      .req_hold    (req_hold),
      .full        (full),
      .quat_valid  (quat_valid_ff),
      .center      (center_ff),
      .q_push      (mid_push),
      .q_full      (mid_full),
      .q_data      (mid_wr_data)
   );

   // Classified points waiting for the arithmetic pipe.
   qpr_fifo #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (mid_push),
      .wr_data (mid_wr_data),
      .full    (mid_full),
      .pop     (mid_pop),
      .rd_data (mid_rd_data),
      .empty   (mid_empty)
   );

   qpr_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (mid_empty),
      .q_data   (mid_rd_data),
      .q_pop    (mid_pop),
      .mat      (mat),
      .center   (center_ff),
      .out_full (res_full),
      .out_push (res_push),
      .out_data (res_wr_data)
   );

   // Finished results waiting for the receiver.
   qpr_fifo #(
      .WIDTH (RES_BITS),
      .DEPTH (OUT_DEPTH)
   ) u_res_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data (res_wr_data),
      .full    (res_full),
      .pop     (pop),
      .rd_data (res_rd_data),
      .empty   (empty)
   );

   assign rsp_status = res_rd_data[STATUS_BITS-1:0];
   assign rsp_out_z  = res_rd_data[STATUS_BITS +: COORD_BITS];
   assign rsp_out_y  = res_rd_data[STATUS_BITS + COORD_BITS +: COORD_BITS];
   assign rsp_out_x  = res_rd_data[STATUS_BITS + 2 * COORD_BITS +: COORD_BITS];

endmodule

/* hdl/qpr_checker.sv */
// Port-level checks of the rotation unit and their binding to the top level.
`timescale 1ns / 1ps
`include "quaternion_point_rotation_unit_macros.svh"

module qpr_checker import qpr_pkg::*; #(
   parameter int COORD_BITS = 24
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         push,
   input logic                         full,
   input logic                         empty,
   input logic                         pop,
   input logic signed [COORD_BITS-1:0] rsp_out_x,
   input logic signed [COORD_BITS-1:0] rsp_out_y,
   input logic signed [COORD_BITS-1:0] rsp_out_z,
   input logic [STATUS_BITS-1:0]       rsp_status
);

   localparam logic [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   // Both queues come out of reset empty.
   `QPR_ASSERT_NOW(a_reset_empty, clock, reset, $past(reset), empty && !full)

   // Input backpressure only rises on the edge of an accepted transaction.
   `QPR_ASSERT_NOW(a_full_rise, clock, reset, $rose(full), $past(push && !full))

   // A saturated result has a coordinate pinned to a range limit.
   `QPR_ASSERT_NOW(a_sat_pinned, clock, reset, !empty && rsp_status == ST_SATURATED, rsp_out_x == CMAX || rsp_out_x == CMIN || rsp_out_y == CMAX || rsp_out_y == CMIN || rsp_out_z == CMAX || rsp_out_z == CMIN)

   // A waiting result stays put until popped.
   `QPR_ASSERT_NEXT(a_rsp_hold, clock, reset, !empty && !pop, !empty && $stable(rsp_out_x) && $stable(rsp_out_y) && $stable(rsp_out_z) && $stable(rsp_status))

endmodule

bind quaternion_point_rotation_unit qpr_checker #(
   .COORD_BITS (COORD_BITS)
) u_qpr_checker (
   .clock      (clock),
   .reset      (reset),
   .push       (push),
   .full       (full),
   .empty      (empty),
   .pop        (pop),
   .rsp_out_x  (rsp_out_x),
   .rsp_out_y  (rsp_out_y),
   .rsp_out_z  (rsp_out_z),
   .rsp_status (rsp_status)
);

/* tb/quaternion_point_rotation_unit_test.sv */
// Self-checking testbench: rotates points through the unit and checks each result.
`timescale 1ns / 1ps

module quaternion_point_rotation_unit_test import qpr_pkg::*; ();

   localparam int COORD_BITS   = 24;
   localparam int QUAT_BITS    = 16;
   localparam int CSR_BITS     = (COORD_BITS > QUAT_BITS) ? COORD_BITS : QUAT_BITS;
   localparam int COORD_MAX    = (1 << (COORD_BITS - 1)) - 1;
   localparam int COORD_MIN    = -(1 << (COORD_BITS - 1));
   localparam int QUAT_ONE     = 1 << (QUAT_BITS - 2);
   localparam int MAT_SHIFT    = 2 * (QUAT_BITS - 2) - MAT_FRAC;
   localparam int LIMIT_CYCLES = 200000;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
      logic                         hold;
   } point_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
      status_type                   status;
   } rotated_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         push = 1'b0;
   logic                         full;
   logic signed [COORD_BITS-1:0] req_coord_x = '0;
   logic signed [COORD_BITS-1:0] req_coord_y = '0;
   logic signed [COORD_BITS-1:0] req_coord_z = '0;
   logic                         req_hold = 1'b0;
   logic                         empty;
   logic                         pop = 1'b0;
   logic signed [COORD_BITS-1:0] rsp_out_x;
   logic signed [COORD_BITS-1:0] rsp_out_y;
   logic signed [COORD_BITS-1:0] rsp_out_z;
   logic [STATUS_BITS-1:0]       rsp_status;
   logic                         csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0]    csr_index = '0;
   logic [CSR_BITS-1:0]          csr_wdata = '0;

   // Mirror of the configuration registers and the derived rotation matrix.
   longint        q_w = QUAT_ONE;
   longint        q_x = 0;
   longint        q_y = 0;
   longint        q_z = 0;
   longint        ctr[3] = '{0, 0, 0};
   bit            rot_enabled = 1'b0;
   mat_entry_type rot_m[MAT_ENTRIES] = '{default: '0};

   point_type   pending_points[$];
   rotated_type predicted_rotations[$];

   bit idling_on = 1'b1;
   bit req_taken = 1'b0;
   int send_gap = 0;
   int recv_gap = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   quaternion_point_rotation_unit #(
      .COORD_BITS(COORD_BITS),
      .QUAT_BITS (QUAT_BITS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_coord_x(req_coord_x),
      .req_coord_y(req_coord_y),
      .req_coord_z(req_coord_z),
      .req_hold   (req_hold),
      .empty      (empty),
      .pop        (pop),
      .rsp_out_x  (rsp_out_x),
      .rsp_out_y  (rsp_out_y),
      .rsp_out_z  (rsp_out_z),
      .rsp_status (rsp_status),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Round a Q4.28 product sum to Q2.16, half toward plus infinity, then clamp.
   function automatic mat_entry_type fix_entry(longint exact);
      longint v;
      v = (exact + (longint'(1) << (MAT_SHIFT - 1))) >>> MAT_SHIFT;
      if (v > MAT_MAX) v = MAT_MAX;
      else if (v < MAT_MIN) v = MAT_MIN;
      return mat_entry_type'(v);
   endfunction

   // Recompute the matrix from the mirrored quaternion on every register write,
   // whatever register was written; the unit tracks its registers continuously.
   function automatic void rebuild_rotation();
      longint one;
      one = longint'(1) << (2 * (QUAT_BITS - 2));
      rot_m[0] = fix_entry(one - 2 * (q_y * q_y + q_z * q_z));
      rot_m[1] = fix_entry(2 * (q_x * q_y - q_z * q_w));
      rot_m[2] = fix_entry(2 * (q_x * q_z + q_y * q_w));
      rot_m[3] = fix_entry(2 * (q_x * q_y + q_z * q_w));
      rot_m[4] = fix_entry(one - 2 * (q_x * q_x + q_z * q_z));
      rot_m[5] = fix_entry(2 * (q_y * q_z - q_x * q_w));
      rot_m[6] = fix_entry(2 * (q_x * q_z - q_y * q_w));
      rot_m[7] = fix_entry(2 * (q_y * q_z + q_x * q_w));
      rot_m[8] = fix_entry(one - 2 * (q_x * q_x + q_y * q_y));
   endfunction

   // Expected result of one point under the current configuration.
   function automatic rotated_type rotate_point(point_type p);
      rotated_type r;
      longint   pv[3];
      longint   res[3];
      longint   acc;
      longint   v;
      bit       clipped;
      pv[0] = $signed(p.x);
      pv[1] = $signed(p.y);
      pv[2] = $signed(p.z);
      // Not-ready wins over hold: both pass the point through untouched.
      if (!rot_enabled || p.hold) begin
         r.x = p.x;
         r.y = p.y;
         r.z = p.z;
         r.status = rot_enabled ? ST_HELD : ST_NOT_READY;
         return r;
      end
      clipped = 1'b0;
      for (int i = 0; i < 3; i++) begin
         acc = longint'(rot_m[3*i])     * (pv[0] - ctr[0])
             + longint'(rot_m[3*i + 1]) * (pv[1] - ctr[1])
             + longint'(rot_m[3*i + 2]) * (pv[2] - ctr[2]);
         v = ((acc + (longint'(1) << (MAT_FRAC - 1))) >>> MAT_FRAC) + ctr[i];
         if (v > COORD_MAX) begin
            v = COORD_MAX;
            clipped = 1'b1;
         end else if (v < COORD_MIN) begin
            v = COORD_MIN;
            clipped = 1'b1;
         end
         res[i] = v;
      end
      r.x = COORD_BITS'(res[0]);
      r.y = COORD_BITS'(res[1]);
      r.z = COORD_BITS'(res[2]);
      r.status = clipped ? ST_SATURATED : ST_ROTATED;
      return r;
   endfunction

   // Driver: advance to the next point only once the current one is taken.
   always @(negedge clock) begin
      point_type p;
      if (reset) begin
         push <= 1'b0;
      end else if (!push || req_taken) begin
         if (send_gap > 0) begin
            push <= 1'b0;
            send_gap--;
         end else if (pending_points.size() > 0) begin
            p = pending_points.pop_front();
            req_coord_x <= p.x;
            req_coord_y <= p.y;
            req_coord_z <= p.z;
            req_hold    <= p.hold;
            push        <= 1'b1;
            if (idling_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 10);
         end else begin
            push <= 1'b0;
         end
      end
   end

   // Receiver: pop by default, drop pop for random bursts.
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (recv_gap > 0) begin
         pop <= 1'b0;
         recv_gap--;
      end else begin
         pop <= 1'b1;
         if (idling_on && $urandom_range(0, 7) == 0) recv_gap = $urandom_range(1, 10);
      end
   end

   // Predict at the edge where an input transaction is taken.
   always @(posedge clock) begin
      point_type p;
      if (!reset && push && !full) begin
         p.x = req_coord_x;
         p.y = req_coord_y;
         p.z = req_coord_z;
         p.hold = req_hold;
         predicted_rotations = {predicted_rotations, rotate_point(p)};
         req_taken <= 1'b1;
      end else begin
         req_taken <= 1'b0;
      end
   end

   // Monitor: compare every result transaction with the oldest prediction.
   always @(posedge clock) begin
      rotated_type want;
      if (!reset && pop && !empty) begin
         if (predicted_rotations.size() == 0) begin
            $display("%0t: unexpected result x=%0d y=%0d z=%0d status=%0d", $time,
                     rsp_out_x, rsp_out_y, rsp_out_z, rsp_status);
            mismatch_count++;
         end else begin
            want = predicted_rotations.pop_front();
            if (rsp_out_x !== want.x || rsp_out_y !== want.y || rsp_out_z !== want.z ||
                rsp_status !== want.status) begin
               $display("%0t: mismatch expected x=%0d y=%0d z=%0d status=%0d", $time,
                        $signed(want.x), $signed(want.y), $signed(want.z), want.status);
               $display("%0t:          actual   x=%0d y=%0d z=%0d status=%0d", $time,
                        rsp_out_x, rsp_out_y, rsp_out_z, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: timeout, %0d results still outstanding", $time,
                  predicted_rotations.size());
         $display("FAIL quaternion_point_rotation_unit");
         $finish;
      end
   end

   task automatic add_point(int x, int y, int z, bit hold);
      point_type p;
      p.x = COORD_BITS'(x);
      p.y = COORD_BITS'(y);
      p.z = COORD_BITS'(z);
      p.hold = hold;
      pending_points = {pending_points, p};
   endtask

   // Hold until every queued point is sent and every result has come back.
   task automatic drain_pipeline();
      while (pending_points.size() != 0 || push || predicted_rotations.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // One register write per falling edge; csr_we stays high across a burst.
   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_BITS-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         REG_QUAT_W:   q_w = longint'($signed(data[QUAT_BITS-1:0]));
         REG_QUAT_X:   q_x = longint'($signed(data[QUAT_BITS-1:0]));
         REG_QUAT_Y:   q_y = longint'($signed(data[QUAT_BITS-1:0]));
         REG_QUAT_Z:   q_z = longint'($signed(data[QUAT_BITS-1:0]));
         REG_CENTER_X: ctr[0] = longint'($signed(data[COORD_BITS-1:0]));
         REG_CENTER_Y: ctr[1] = longint'($signed(data[COORD_BITS-1:0]));
         REG_CENTER_Z: ctr[2] = longint'($signed(data[COORD_BITS-1:0]));
         REG_QUAT_VALID: rot_enabled = data[0];
         default: ;
      endcase
      rebuild_rotation();
   endtask

   // End a write burst and let the matrix settle before new points arrive.
   task automatic close_config();
      @(negedge clock);
      csr_we <= 1'b0;
      repeat (4) @(negedge clock);
   endtask

   task automatic load_all(int w, int x, int y, int z, int cx, int cy, int cz, bit valid);
      write_reg(REG_QUAT_W, CSR_BITS'(w));
      write_reg(REG_QUAT_X, CSR_BITS'(x));
      write_reg(REG_QUAT_Y, CSR_BITS'(y));
      write_reg(REG_QUAT_Z, CSR_BITS'(z));
      write_reg(REG_CENTER_X, CSR_BITS'(cx));
      write_reg(REG_CENTER_Y, CSR_BITS'(cy));
      write_reg(REG_CENTER_Z, CSR_BITS'(cz));
      write_reg(REG_QUAT_VALID, CSR_BITS'(valid));
      close_config();
   endtask

   // Mostly modest coordinates so rotations stay in range, plus extremes and full range.
   function automatic int rand_coord();
      case ($urandom_range(0, 9))
         0:       return COORD_MAX;
         1:       return COORD_MIN;
         2, 3:    return $signed(COORD_BITS'($urandom));
         default: return int'($urandom_range(0, 1 << 19)) - (1 << 18);
      endcase
   endfunction

   function automatic int rand_center();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return $signed(COORD_BITS'($urandom));
         default: return int'($urandom_range(0, 1 << 17)) - (1 << 16);
      endcase
   endfunction

   // Random quaternion: normalized to a real rotation, or raw components.
   task automatic random_config(bit unit_length);
      real a[4];
      real n;
      int  q[4];
      for (int i = 0; i < 4; i++) begin
         a[i] = $urandom_range(0, 2000);
         a[i] = a[i] - 1000.0;
      end
      n = $sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3]);
      for (int i = 0; i < 4; i++)
         q[i] = (unit_length && n > 1.0) ? $rtoi(a[i] / n * QUAT_ONE)
                                         : int'($urandom_range(0, 2 * QUAT_ONE)) - QUAT_ONE;
      load_all(q[0], q[1], q[2], q[3], rand_center(), rand_center(), rand_center(), 1'b1);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Out of reset no quaternion is valid: everything passes, even held points.
      add_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
      add_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
      add_point('h555555, $signed(24'hAAAAAA), 0, 1'b0);
      drain_pipeline();

      // Identity rotation, zero center; include a held point.
      load_all(QUAT_ONE, 0, 0, 0, 0, 0, 0, 1'b1);
      add_point(0, 0, 0, 1'b0);
      add_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
      add_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
      add_point(123457, -7, 1, 1'b0);
      drain_pipeline();

      // Half turn about z: negating the most negative coordinate saturates.
      load_all(0, 0, 0, QUAT_ONE, 0, 0, 0, 1'b1);
      add_point(COORD_MIN, 0, 0, 1'b0);
      add_point(COORD_MAX, COORD_MIN, 5, 1'b0);
      add_point(256, -513, 1001, 1'b0);
      drain_pipeline();

      // Non-unit quaternion, every component at one, center at the extremes.
      load_all(QUAT_ONE, QUAT_ONE, QUAT_ONE, QUAT_ONE, COORD_MAX, COORD_MIN, 0, 1'b1);
      add_point(COORD_MIN, COORD_MAX, 0, 1'b0);
      add_point(0, 0, 0, 1'b0);
      add_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
      drain_pipeline();

      // Every quaternion component at minus one, odd center.
      load_all(-QUAT_ONE, -QUAT_ONE, -QUAT_ONE, -QUAT_ONE, 7, -7, 3, 1'b1);
      add_point(1, 1, 1, 1'b0);
      add_point(-1, 2, -3, 1'b0);
      add_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
      drain_pipeline();

      // Quarter turn about x, entries that need rounding.
      load_all(11585, 11585, 0, 0, 1000, -1000, 0, 1'b1);
      add_point(1000, -1000, 1, 1'b0);
      add_point(4096, 333, -77, 1'b0);
      drain_pipeline();

      // Random phases; each ends with a full drain before the next setting.
      for (int ph = 0; ph < 10; ph++) begin
         if (ph == 9) idling_on = 1'b0;
         if (ph == 4) begin
            // Drop the valid flag alone; the quaternion stays loaded.
            write_reg(REG_QUAT_VALID, '0);
            close_config();
         end else begin
            random_config(ph % 2 == 0);
         end
         repeat (130) add_point(rand_coord(), rand_coord(), rand_coord(),
                                $urandom_range(0, 7) == 0);
         drain_pipeline();
      end

      if (mismatch_count == 0)
         $display("PASS quaternion_point_rotation_unit");
      else
         $display("FAIL quaternion_point_rotation_unit");
      $finish;
   end

endmodule
